@@ hdl/mrw_pkg.sv @@
package mrw_pkg;

    // Default operand width of candidate and witness
    localparam int NUM_WIDTH_DEF = 63;

endpackage

@@ hdl/miller_rabin_witness_test.sv @@
// One Miller-Rabin round: does witness a prove candidate n composite?
// Input: raise start with candidate and witness; the item is taken at a
// rising edge where start is high and busy is low. busy stays high until
// the verdict is out. Output: done pulses for one cycle with
// probably_prime valid (1: no evidence of compositeness, 0: composite).
// The receiver cannot stall; the verdict is shown exactly once.
// All work runs through one shift-add modular multiplier that handles one
// bit of its second operand per cycle. With n - 1 = d * 2^s, B the bit
// length of d and P its number of set bits, an item makes one reduction
// of the witness, B - 1 squarings, P multiplies and up to s - 1 final
// squarings. Candidates below 4 are decided without the multiplier. One
// item at a time. Reset clears the sequencer and drops any item in
// progress; busy and done are low after reset. A new item may be given
// in the cycle done is high.
module miller_rabin_witness_test #(
    parameter int NUM_WIDTH = mrw_pkg::NUM_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [NUM_WIDTH-1:0] candidate,
    input  logic [NUM_WIDTH-1:0] witness,
    output logic                 done,
    output logic                 probably_prime
);

    localparam int SW = $clog2(NUM_WIDTH);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SPLIT = 4'd1;
    localparam logic [3:0] ST_RED   = 4'd2;
    localparam logic [3:0] ST_POW   = 4'd3;
    localparam logic [3:0] ST_PMUL  = 4'd4;
    localparam logic [3:0] ST_PSQ   = 4'd5;
    localparam logic [3:0] ST_CHECK = 4'd6;
    localparam logic [3:0] ST_SLOOP = 4'd7;
    localparam logic [3:0] ST_SQR   = 4'd8;

    logic [3:0]           state_reg, state_next;
    logic                 go_reg, go_next;
    logic                 done_reg, done_next;
    logic                 verdict_reg, verdict_next;
    logic [SW-1:0]        s_reg, s_next;
    logic [NUM_WIDTH-1:0] n_reg, n_next;
    logic [NUM_WIDTH-1:0] nm1_reg, nm1_next;
    logic [NUM_WIDTH-1:0] d_reg, d_next;
    logic [NUM_WIDTH-1:0] base_reg, base_next;
    logic [NUM_WIDTH-1:0] acc_reg, acc_next;
    logic [NUM_WIDTH-1:0] opx_reg, opx_next;
    logic [NUM_WIDTH-1:0] opy_reg, opy_next;

    logic                 mm_done;
    logic [NUM_WIDTH-1:0] mm_product;

    mrw_mulmod #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (go_reg),
        .op_x    (opx_reg),
        .op_y    (opy_reg),
        .modulus (n_reg),
        .done    (mm_done),
        .product (mm_product)
    );

    always_comb
    begin
        state_next   = state_reg;
        go_next      = 1'b0;
        done_next    = 1'b0;
        verdict_next = verdict_reg;
        s_next       = s_reg;
        n_next       = n_reg;
        nm1_next     = nm1_reg;
        d_next       = d_reg;
        base_next    = base_reg;
        acc_next     = acc_reg;
        opx_next     = opx_reg;
        opy_next     = opy_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    n_next     = candidate;
                    nm1_next   = candidate - NUM_WIDTH'(1);
                    d_next     = candidate - NUM_WIDTH'(1);
                    base_next  = witness;
                    s_next     = '0;
                    state_next = ST_SPLIT;
                end
            end
            ST_SPLIT:
            begin
                if (n_reg[NUM_WIDTH-1:2] == '0)
                begin
                    verdict_next = (n_reg == NUM_WIDTH'(2)) || (n_reg == NUM_WIDTH'(3));
                    done_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
                else if (!d_reg[0])
                begin
                    d_next = d_reg >> 1;
                    s_next = s_reg + SW'(1);
                end
                else
                begin
                    // Reduce the witness: 1 * a mod n
                    opx_next   = NUM_WIDTH'(1);
                    opy_next   = base_reg;
                    go_next    = 1'b1;
                    state_next = ST_RED;
                end
            end
            ST_RED:
            begin
                if (mm_done)
                begin
                    base_next  = mm_product;
                    acc_next   = NUM_WIDTH'(1);
                    state_next = ST_POW;
                end
            end
            ST_POW:
            begin
                if (d_reg == '0)
                begin
                    state_next = ST_CHECK;
                end
                else if (d_reg[0])
                begin
                    opx_next   = acc_reg;
                    opy_next   = base_reg;
                    go_next    = 1'b1;
                    state_next = ST_PMUL;
                end
                else
                begin
                    opx_next   = base_reg;
                    opy_next   = base_reg;
                    go_next    = 1'b1;
                    state_next = ST_PSQ;
                end
            end
            ST_PMUL:
            begin
                if (mm_done)
                begin
                    acc_next = mm_product;
                    if (d_reg == NUM_WIDTH'(1))
                    begin
                        // Last exponent bit: skip the unused squaring
                        d_next     = '0;
                        state_next = ST_POW;
                    end
                    else
                    begin
                        opx_next   = base_reg;
                        opy_next   = base_reg;
                        go_next    = 1'b1;
                        state_next = ST_PSQ;
                    end
                end
            end
            ST_PSQ:
            begin
                if (mm_done)
                begin
                    base_next  = mm_product;
                    d_next     = d_reg >> 1;
                    state_next = ST_POW;
                end
            end
            ST_CHECK:
            begin
                if ((acc_reg == NUM_WIDTH'(1)) || (acc_reg == nm1_reg))
                begin
                    verdict_next = 1'b1;
                    done_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SLOOP;
                end
            end
            ST_SLOOP:
            begin
                if (s_reg <= SW'(1))
                begin
                    verdict_next = 1'b0;
                    done_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    s_next     = s_reg - SW'(1);
                    opx_next   = acc_reg;
                    opy_next   = acc_reg;
                    go_next    = 1'b1;
                    state_next = ST_SQR;
                end
            end
            ST_SQR:
            begin
                if (mm_done)
                begin
                    acc_next = mm_product;
                    if (mm_product == nm1_reg)
                    begin
                        verdict_next = 1'b1;
                        done_next    = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_SLOOP;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            go_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            go_reg    <= go_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
        s_reg       <= s_next;
        n_reg       <= n_next;
        nm1_reg     <= nm1_next;
        d_reg       <= d_next;
        base_reg    <= base_next;
        acc_reg     <= acc_next;
        opx_reg     <= opx_next;
        opy_reg     <= opy_next;
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign probably_prime = verdict_reg;

endmodule

@@ hdl/mrw_mulmod.sv @@
module mrw_mulmod #(
    parameter int NUM_WIDTH = mrw_pkg::NUM_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 go,
    input  logic [NUM_WIDTH-1:0] op_x,
    input  logic [NUM_WIDTH-1:0] op_y,
    input  logic [NUM_WIDTH-1:0] modulus,
    output logic                 done,
    output logic [NUM_WIDTH-1:0] product
);

    localparam int CW = $clog2(NUM_WIDTH);

    logic                 run_reg;
    logic                 done_reg;
    logic [CW-1:0]        cnt_reg;
    logic [NUM_WIDTH-1:0] acc_reg;
    logic [NUM_WIDTH-1:0] y_reg;

    logic [NUM_WIDTH:0]   dbl;
    logic [NUM_WIDTH-1:0] dbl_red;
    logic [NUM_WIDTH:0]   sum;
    logic [NUM_WIDTH-1:0] acc_next;

    // One bit of y per cycle, most significant first: double, then add x
    always_comb
    begin
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, modulus}) ? NUM_WIDTH'(dbl - {1'b0, modulus})
                                           : NUM_WIDTH'(dbl);
        sum     = {1'b0, dbl_red} + (y_reg[NUM_WIDTH-1] ? {1'b0, op_x}
                                                        : {(NUM_WIDTH+1){1'b0}});
        acc_next = (sum >= {1'b0, modulus}) ? NUM_WIDTH'(sum - {1'b0, modulus})
                                            : NUM_WIDTH'(sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(NUM_WIDTH - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            acc_reg <= '0;
            y_reg   <= op_y;
        end
        else if (run_reg)
        begin
            acc_reg <= acc_next;
            y_reg   <= {y_reg[NUM_WIDTH-2:0], 1'b0};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

@@ hdl/mrw_checker.sv @@
module mrw_checker #(
    parameter int NUM_WIDTH = mrw_pkg::NUM_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic [NUM_WIDTH-1:0] candidate,
    input  logic                 done,
    input  logic                 probably_prime
);

    // An accepted item keeps the block busy until its verdict
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the block busy");

    // A verdict only follows work, and the block is free when it shows
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("verdict strobe without preceding work");

    // Two and three are prime whatever the witness
    a_small_prime: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (candidate == 2 || candidate == 3))
            |-> ##2 (done && probably_prime))
        else $error("small prime not reported as prime");

    // Zero and one are never prime
    a_small_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (candidate == 0 || candidate == 1))
            |-> ##2 (done && !probably_prime))
        else $error("zero or one reported as prime");

endmodule

bind miller_rabin_witness_test mrw_checker #(
    .NUM_WIDTH (NUM_WIDTH)
) u_mrw_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .candidate      (candidate),
    .done           (done),
    .probably_prime (probably_prime)
);

@@ sim/miller_rabin_witness_test_checker.sv @@
module miller_rabin_witness_test_checker #(
    parameter int NUM_WIDTH = mrw_pkg::NUM_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic [NUM_WIDTH-1:0] candidate,
    input  logic [NUM_WIDTH-1:0] witness,
    input  logic                 done,
    input  logic                 probably_prime,
    output int                   errors,
    output int                   pending
);

    typedef logic [63:0] word_t;

    bit verdict_queue[$];
    int mismatches;

    // Exact (x * y) mod m through a 128-bit product
    function automatic word_t mul_mod(word_t x, word_t y, word_t m);
        logic [127:0] prod;
        prod = {64'd0, x} * {64'd0, y};
        prod = prod % {64'd0, m};
        return prod[63:0];
    endfunction

    function automatic bit strong_probable_prime(word_t n, word_t a);
        word_t nm1;
        word_t d;
        word_t x;
        word_t base;
        word_t e;
        int    s;
        if (n < 64'd4)
            return (n == 64'd2) || (n == 64'd3);
        nm1 = n - 64'd1;
        d = nm1;
        s = 0;
        while (d[0] == 1'b0)
        begin
            d = d >> 1;
            s++;
        end
        base = a % n;
        x = 64'd1;
        e = d;
        while (e != 64'd0)
        begin
            if (e[0])
                x = mul_mod(x, base, n);
            base = mul_mod(base, base, n);
            e = e >> 1;
        end
        if (x == 64'd1 || x == nm1)
            return 1'b1;
        for (int r = 1; r < s; r++)
        begin
            x = mul_mod(x, x, n);
            if (x == nm1)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bit want;
        if (!rst_n)
        begin
            verdict_queue.delete();
            mismatches = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            // retire the oldest verdict before taking a new item at the same edge
            if (done)
            begin
                if (verdict_queue.size() == 0)
                begin
                    $error("probably_prime: expected nothing, got %0b", probably_prime);
                    mismatches++;
                end
                else
                begin
                    want = verdict_queue.pop_front();
                    if (probably_prime !== want)
                    begin
                        $error("probably_prime: expected %0b, got %0b", want, probably_prime);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
                verdict_queue.push_back(strong_probable_prime(
                    64'(candidate), 64'(witness)));
            errors  <= mismatches;
            pending <= verdict_queue.size();
        end
    end

endmodule

@@ sim/miller_rabin_witness_test_tb.sv @@
module miller_rabin_witness_test_tb;

    localparam int NW = mrw_pkg::NUM_WIDTH_DEF;
    localparam int STALL_LIMIT = 60000;

    localparam logic [NW-1:0] NUM_MAX = {NW{1'b1}};

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    logic [NW-1:0] candidate = '0;
    logic [NW-1:0] witness = '0;
    logic          done;
    logic          probably_prime;
    int            errors;
    int            pending;
    int            stall_count = 0;
    bit            burst = 1'b0;

    // primes (several with a long run of trailing zeros in n-1) and strong pseudoprimes
    logic [63:0] known_numbers [12] = '{
        64'd7, 64'd97, 64'd65537, 64'd998244353, 64'd3221225473,
        64'd4294967291, 64'd2305843009213693951, 64'd4179340454199820289,
        64'd9223372036854775783, 64'd2047, 64'd3215031751, 64'd25326001
    };

    miller_rabin_witness_test #(.NUM_WIDTH(NW)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .candidate     (candidate),
        .witness       (witness),
        .done          (done),
        .probably_prime(probably_prime)
    );

    miller_rabin_witness_test_checker #(.NUM_WIDTH(NW)) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .candidate     (candidate),
        .witness       (witness),
        .done          (done),
        .probably_prime(probably_prime),
        .errors        (errors),
        .pending       (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("miller_rabin_witness_test_tb failed");
            $finish;
        end
    end

    function automatic logic [NW-1:0] random_word();
        return NW'({$urandom, $urandom});
    endfunction

    // random value of exactly len bits
    function automatic logic [NW-1:0] random_of_length(int len);
        logic [NW-1:0] v;
        v = random_word() & (NUM_MAX >> (NW - len));
        v[len-1] = 1'b1;
        return v;
    endfunction

    // hold start high across back-to-back items; drop it only for a gap
    task automatic send_item(logic [NW-1:0] n, logic [NW-1:0] a);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        candidate <= n;
        witness   <= a;
        do
            @(posedge clk);
        while (busy);
    endtask

    initial
    begin
        logic [NW-1:0] n;
        logic [NW-1:0] a;
        logic [63:0]   multiple;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // small candidates, witness ignored
        send_item(NW'(0), NW'(0));
        send_item(NW'(1), NUM_MAX);
        send_item(NW'(2), NW'(0));
        send_item(NW'(3), NUM_MAX);
        // even candidates: only a^(n-1) is tested
        send_item(NW'(4), NW'(1));
        send_item(NW'(4), NW'(3));
        send_item(NUM_MAX - 1'b1, NW'(3));
        // witness zero, one, n-1, a multiple of n, and reduced from the top
        send_item(NW'(5), NW'(0));
        send_item(NW'(5), NW'(1));
        send_item(NW'(5), NW'(4));
        send_item(NW'(5), NW'(10));
        send_item(NW'(5), NUM_MAX);
        send_item(NW'(1000003), NW'(3000009));
        send_item(NW'(9), NW'(2));
        // pseudoprimes, long squaring chains and the widest candidates
        send_item(NW'(561), NW'(2));
        send_item(NW'(2047), NW'(2));
        send_item(NW'(64'd3215031751), NW'(2));
        send_item(NW'(65537), NW'(3));
        send_item(NW'(64'd998244353), NW'(64'd998244352));
        send_item(NW'(64'd4179340454199820289), NW'(3));
        send_item(NW'(64'd2305843009213693951), NW'(2));
        send_item(NUM_MAX, NW'(2));
        send_item(NUM_MAX, NUM_MAX - 1'b1);
        send_item(NW'(64'd9223372036854775783), NUM_MAX);

        for (int i = 0; i < 100; i++)
        begin
            if (i % 16 == 0)
                burst = ($urandom_range(0, 2) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2: n = NW'(known_numbers[$urandom_range(0, 11)]);
                8:       n = random_of_length($urandom_range(3, NW)) & ~NW'(1);
                9:       n = NW'($urandom_range(0, 20));
                default:
                begin
                    n = random_of_length($urandom_range(2, NW));
                    n[0] = 1'b1;
                end
            endcase
            case ($urandom_range(0, 9))
                0: a = '0;
                1: a = NW'(1);
                2: a = n - 1'b1;
                3:
                begin
                    multiple = 64'(n) * 64'($urandom_range(1, 1000));
                    a = (multiple >> NW) == 64'd0 ? NW'(multiple) : n;
                end
                default: a = random_word();
            endcase
            send_item(n, a);
        end
        start <= 1'b0;

        // let the count of the last accepted item settle before waiting on it
        do
            @(posedge clk);
        while (pending != 0);
        repeat (30) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("miller_rabin_witness_test_tb passed");
        else
            $display("miller_rabin_witness_test_tb failed");
        $finish;
    end

endmodule
